### hdl/tgs_pkg.sv
// Shared constants and codes for the thermal guard supervisor.
package tgs_pkg;

   // Widths of temperatures, limits and the recovery timer.
   localparam int TEMP_W  = 11;
   localparam int RAW_W   = 16;
   localparam int TICK_W  = 20;
   localparam int COUNT_W = TICK_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TICK_W;

   // Register reset values: 80.0 and 3.0 degrees in eighths, 60000 ticks.
   localparam logic signed [TEMP_W-1:0] OVER_TEMP_RESET = 11'sd640;
   localparam logic [TEMP_W-1:0]        DIFF_LIMIT_RESET = 11'd24;
   localparam logic [TICK_W-1:0]        RECOVERY_RESET = 20'd60000;

   // Event codes of an input beat.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_TEMP   = 2'd1;
   localparam logic [1:0] OP_SENSOR = 2'd2;
   localparam logic [1:0] OP_EXPIRE = 2'd3;

   // Supervisor modes.
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_OK    = 2'd1;
   localparam logic [1:0] MODE_FAIL  = 2'd2;
   localparam logic [1:0] MODE_GUARD = 2'd3;

   // Reason codes reported with a mode change.
   localparam logic [2:0] RSN_NONE   = 3'd0;
   localparam logic [2:0] RSN_POWER  = 3'd1;
   localparam logic [2:0] RSN_SENSOR = 3'd2;
   localparam logic [2:0] RSN_HOT    = 3'd3;
   localparam logic [2:0] RSN_DIFF   = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_TEMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY  = 2'd2;

endpackage

### hdl/thermal_guard_supervisor_core.sv
// Thermal guard supervisor: mode control, sensor decode and recovery timer.
//
// Each request beat carries one event (tick, sensor pair, sensor failure or
// forced expiry) and yields exactly one response beat. A beat is captured in
// an input register, and the whole mode update is combinational logic
// between that register and the response register, so the block sustains one
// beat per clock while rsp_ready does not hold the response register. The
// response register holds a finished beat while the next one is taken in.
// Configuration writes are always ready and take effect on the next event;
// indexes beyond the recovery timer register are ignored.
module thermal_guard_supervisor_core
   import tgs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [RAW_W-1:0]             req_guard_raw,
   input  logic [RAW_W-1:0]             req_ref_raw,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_mode,
   output logic                         rsp_enable,
   output logic                         rsp_changed,
   output logic [2:0]                   rsp_reason,
   output logic                         rsp_store_guard_record,
   output logic signed [TEMP_W-1:0]     rsp_guard_temp,
   output logic [TEMP_W-1:0]            rsp_temp_diff,
   output logic signed [COUNT_W-1:0]    rsp_time_left,
   // Configuration write channel.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic signed [TEMP_W-1:0] over_temp_ff;
   logic [TEMP_W-1:0]        diff_limit_ff;
   logic [TICK_W-1:0]        recovery_ff;

   // Supervisor state.
   logic [1:0]               cur_mode_ff, cur_mode_in;
   logic [1:0]               last_mode_ff, last_mode_in;
   logic                     last_enable_ff, last_enable_in;
   logic [2:0]               pend_rsn_ff, pend_rsn_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;

   // Input stage.
   logic                     in_valid_ff;
   logic [1:0]               in_op_ff;
   logic [RAW_W-1:0]         in_guard_ff, in_ref_ff;

   // Response stage.
   logic                     out_valid_ff;
   logic [1:0]               out_mode_ff, out_mode_in;
   logic                     out_enable_ff, out_enable_in;
   logic                     out_changed_ff, out_changed_in;
   logic [2:0]               out_reason_ff, out_reason_in;
   logic                     out_store_ff, out_store_in;
   logic signed [TEMP_W-1:0] out_gtemp_ff, out_gtemp_in;
   logic [TEMP_W-1:0]        out_diff_ff, out_diff_in;
   logic signed [COUNT_W-1:0] out_count_ff;

   logic                     advance;
   logic signed [TEMP_W-1:0] gtemp, rtemp;
   logic signed [TEMP_W:0]   diff_s;
   logic [TEMP_W-1:0]        diff_abs;
   logic [1:0]               mode_mid;
   logic [2:0]               rsn_mid;
   logic signed [COUNT_W-1:0] restart_val;

   // Handshake: the input stage moves on when the response register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;

   // Decode both sensors: the top 11 bits are a signed count of eighths.
   assign gtemp    = $signed(in_guard_ff[RAW_W-1:RAW_W-TEMP_W]);
   assign rtemp    = $signed(in_ref_ff[RAW_W-1:RAW_W-TEMP_W]);
   assign diff_s   = {gtemp[TEMP_W-1], gtemp} - {rtemp[TEMP_W-1], rtemp};
   assign diff_abs = diff_s[TEMP_W] ? TEMP_W'(-diff_s) : diff_s[TEMP_W-1:0];
   assign restart_val = $signed({1'b0, recovery_ff});

   // Event handling followed by the update rule and change detection.
   always_comb begin
      mode_mid  = cur_mode_ff;
      rsn_mid   = pend_rsn_ff;
      count_in  = count_ff;
      out_gtemp_in = '0;
      out_diff_in  = '0;
      case (in_op_ff)
         OP_TICK: begin
            if (count_ff != '1) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         OP_TEMP: begin
            out_gtemp_in = gtemp;
            out_diff_in  = diff_abs;
            if (cur_mode_ff == MODE_OK || cur_mode_ff == MODE_FAIL) begin
               if (gtemp >= over_temp_ff) begin
                  count_in = restart_val;
                  rsn_mid  = RSN_HOT;
                  mode_mid = MODE_GUARD;
               end else if (diff_abs >= diff_limit_ff) begin
                  rsn_mid  = RSN_DIFF;
                  mode_mid = MODE_FAIL;
               end else begin
                  rsn_mid  = RSN_NONE;
                  mode_mid = MODE_OK;
               end
            end
         end
         OP_SENSOR: begin
            count_in = restart_val;
            if (cur_mode_ff == MODE_OK || cur_mode_ff == MODE_FAIL) begin
               rsn_mid  = RSN_SENSOR;
               mode_mid = MODE_FAIL;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase

      // Init always becomes ok; guard ends once the countdown is below zero.
      cur_mode_in = mode_mid;
      if (mode_mid == MODE_INIT) begin
         cur_mode_in = MODE_OK;
      end
      if (mode_mid == MODE_GUARD && count_in[COUNT_W-1]) begin
         cur_mode_in = MODE_OK;
      end

      out_mode_in    = cur_mode_in;
      out_enable_in  = (cur_mode_in == MODE_OK);
      out_changed_in = (out_enable_in != last_enable_ff) || (cur_mode_in != last_mode_ff);
      last_mode_in   = last_mode_ff;
      last_enable_in = last_enable_ff;
      pend_rsn_in    = rsn_mid;
      out_reason_in  = RSN_NONE;
      out_store_in   = 1'b0;
      if (out_changed_in) begin
         last_mode_in   = cur_mode_in;
         last_enable_in = out_enable_in;
         out_reason_in  = rsn_mid;
         pend_rsn_in    = RSN_NONE;
         out_store_in   = (cur_mode_in == MODE_GUARD);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         over_temp_ff  <= OVER_TEMP_RESET;
         diff_limit_ff <= DIFF_LIMIT_RESET;
         recovery_ff   <= RECOVERY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OVER_TEMP: over_temp_ff  <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_DIFF:      diff_limit_ff <= csr_wdata[TEMP_W-1:0];
            CSR_RECOVERY:  recovery_ff   <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_op_ff    <= req_op;
         in_guard_ff <= req_guard_raw;
         in_ref_ff   <= req_ref_raw;
      end
   end

   // Supervisor state advances with each beat that moves to the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff    <= MODE_INIT;
         last_mode_ff   <= MODE_INIT;
         last_enable_ff <= 1'b0;
         pend_rsn_ff    <= RSN_POWER;
         count_ff       <= '0;
      end else if (advance) begin
         cur_mode_ff    <= cur_mode_in;
         last_mode_ff   <= last_mode_in;
         last_enable_ff <= last_enable_in;
         pend_rsn_ff    <= pend_rsn_in;
         count_ff       <= count_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= advance || (out_valid_ff && !rsp_ready);
      end
      if (advance) begin
         out_mode_ff    <= out_mode_in;
         out_enable_ff  <= out_enable_in;
         out_changed_ff <= out_changed_in;
         out_reason_ff  <= out_reason_in;
         out_store_ff   <= out_store_in;
         out_gtemp_ff   <= out_gtemp_in;
         out_diff_ff    <= out_diff_in;
         out_count_ff   <= count_in;
      end
   end

   assign rsp_mode               = out_mode_ff;
   assign rsp_enable             = out_enable_ff;
   assign rsp_changed            = out_changed_ff;
   assign rsp_reason             = out_reason_ff;
   assign rsp_store_guard_record = out_store_ff;
   assign rsp_guard_temp         = out_gtemp_ff;
   assign rsp_temp_diff          = out_diff_ff;
   assign rsp_time_left          = out_count_ff;

   // The countdown never falls below minus one.
   a_count_floor: assert property (@(posedge clock) disable iff (reset)
      count_ff[COUNT_W-1] |-> (count_ff == '1))
      else $error("countdown below minus one");

   // Once a beat has been processed the supervisor never sits in init.
   a_no_init: assert property (@(posedge clock) disable iff (reset)
      advance |=> (cur_mode_ff != MODE_INIT))
      else $error("mode stayed in init after a beat");

   // A reported beat agrees with the state it leaves behind.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_mode == cur_mode_ff && rsp_time_left == count_ff))
      else $error("response does not match supervisor state");

   // Enable follows mode, and a record is only requested on a change into guard.
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_enable == (rsp_mode == MODE_OK))
                     && (!rsp_store_guard_record
                         || (rsp_changed && rsp_mode == MODE_GUARD))
                     && (rsp_changed || rsp_reason == RSN_NONE)))
      else $error("inconsistent response flags");

   // The last reported values always match the mode held in state.
   a_last_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> (last_mode_ff == cur_mode_ff
                   && last_enable_ff == (cur_mode_ff == MODE_OK)))
      else $error("last reported mode out of step");

endmodule
